// File: rtl/brcp_pkg.sv
package brcp_pkg;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int X_W      = 9;
    localparam int Y_W      = 14;
    localparam int COLOR_W  = 8;
    localparam int COL_W    = 9;
    localparam int IDX_W    = 12;
    localparam int DOT_W    = 8;
    localparam int SUM_W    = COLOR_W + 3;

    // Stream packing
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Storage
    localparam int MAX_CELLS_DEF = 4096;
    localparam int PIX_PER_CELL  = 8;
    localparam int PIX_W         = 3 * COLOR_W;
    localparam int CELL_W        = DOT_W + 3 * COLOR_W;

    // Cell word: dot byte low, then red, green, blue
    localparam logic [CELL_W-1:0] CELL_RESET_WORD = {{(3 * COLOR_W){1'b1}}, {DOT_W{1'b0}}};
    localparam logic [COL_W-1:0]  COLS_RESET      = COL_W'(80);

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET_DOT   = 2'd0,
        ACT_CLEAR_DOT = 2'd1,
        ACT_SET_COLOR = 2'd2,
        ACT_SET_BOTH  = 2'd3
    } action_t;

    typedef struct packed {
        logic busy;
        logic cell_we;
        logic pix_we;
    } clr_t;

    // Braille dot bit for (row within cell, column within cell)
    function automatic logic [DOT_W-1:0] dot_mask(input logic [1:0] row, input logic col);
        logic [DOT_W-1:0] m;
        unique case ({row, col})
            3'b000: m = 8'h01;
            3'b001: m = 8'h08;
            3'b010: m = 8'h02;
            3'b011: m = 8'h10;
            3'b100: m = 8'h04;
            3'b101: m = 8'h20;
            3'b110: m = 8'h40;
            3'b111: m = 8'h80;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/brcp_ram.sv
module brcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/brcp_clear.sv
module brcp_clear #(
    parameter int MAX_CELLS = brcp_pkg::MAX_CELLS_DEF,
    localparam int PIX_DEPTH = MAX_CELLS * brcp_pkg::PIX_PER_CELL,
    localparam int PIX_AW = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    output brcp_pkg::clr_t     clr,
    output logic [PIX_AW-1:0]  clr_addr
);
    import brcp_pkg::*;

    logic              busy_reg;
    logic [PIX_AW-1:0] addr_reg;
    logic              last;

    assign last = (addr_reg == PIX_AW'(PIX_DEPTH - 1));

    // Sweep every pixel entry once; cell entries ride along on the low addresses
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end else if (busy_reg) begin
            busy_reg <= !last;
            addr_reg <= last ? '0 : addr_reg + PIX_AW'(1);
        end
    end

    assign clr.busy    = busy_reg;
    assign clr.pix_we  = busy_reg;
    assign clr.cell_we = busy_reg && ({1'b0, addr_reg} < (PIX_AW + 1)'(MAX_CELLS));
    assign clr_addr    = addr_reg;

endmodule

// File: rtl/brcp_engine.sv
module brcp_engine #(
    parameter int MAX_CELLS = brcp_pkg::MAX_CELLS_DEF,
    localparam int CELL_AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
    localparam int PIX_DEPTH = MAX_CELLS * brcp_pkg::PIX_PER_CELL,
    localparam int PIX_AW = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [brcp_pkg::COL_W-1:0]        cfg_cols,
    input  logic                              clr_busy,
    // request side
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [brcp_pkg::ACTION_W-1:0]     in_action,
    input  logic [brcp_pkg::X_W-1:0]          in_x,
    input  logic [brcp_pkg::Y_W-1:0]          in_y,
    input  logic [brcp_pkg::PIX_W-1:0]        in_rgb,
    // result side
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [brcp_pkg::IDX_W-1:0]        out_idx,
    output logic [brcp_pkg::DOT_W-1:0]        out_dot,
    output logic [brcp_pkg::COLOR_W-1:0]      out_red,
    output logic [brcp_pkg::COLOR_W-1:0]      out_green,
    output logic [brcp_pkg::COLOR_W-1:0]      out_blue,
    output logic                              out_oor,
    // cell memory
    output logic                              cell_re,
    output logic [CELL_AW-1:0]                cell_raddr,
    input  logic [brcp_pkg::CELL_W-1:0]       cell_rdata,
    output logic                              cell_we,
    output logic [CELL_AW-1:0]                cell_waddr,
    output logic [brcp_pkg::CELL_W-1:0]       cell_wdata,
    // pixel memory
    output logic                              pix_re,
    output logic [PIX_AW-1:0]                 pix_raddr,
    input  logic [brcp_pkg::PIX_W-1:0]        pix_rdata,
    output logic                              pix_we,
    output logic [PIX_AW-1:0]                 pix_waddr,
    output logic [brcp_pkg::PIX_W-1:0]        pix_wdata
);
    import brcp_pkg::*;

    localparam int Q_W    = Y_W - 2;
    localparam int PROD_W = Q_W + COL_W;
    localparam int OFF_W  = COL_W + 3;
    localparam int WIDE_W = PROD_W + 3;
    localparam int K_W    = $clog2(PIX_PER_CELL + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_CELL,
        S_SUM,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    action_t               act_reg, act_next;
    logic [X_W-1:0]        x_reg, x_next;
    logic [Y_W-1:0]        y_reg, y_next;
    logic [PIX_W-1:0]      rgb_reg, rgb_next;
    logic [PROD_W-1:0]     rowbase_reg, rowbase_next;
    logic [OFF_W-1:0]      offset_reg, offset_next;
    logic [CELL_AW-1:0]    cell_reg, cell_next;
    logic [PIX_AW-1:0]     rowaddr_reg, rowaddr_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic [SUM_W-1:0]      sum_r_reg, sum_r_next;
    logic [SUM_W-1:0]      sum_g_reg, sum_g_next;
    logic [SUM_W-1:0]      sum_b_reg, sum_b_next;
    logic [CELL_W-1:0]     word_reg, word_next;
    logic                  oor_reg, oor_next;
    logic                  out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]      out_idx_reg, out_idx_next;
    logic [DOT_W-1:0]      out_dot_reg, out_dot_next;
    logic [COLOR_W-1:0]    out_r_reg, out_r_next;
    logic [COLOR_W-1:0]    out_g_reg, out_g_next;
    logic [COLOR_W-1:0]    out_b_reg, out_b_next;
    logic                  out_oor_reg, out_oor_next;

    logic [COL_W:0]        stride;
    logic [PROD_W-1:0]     cell_sum;
    logic [WIDE_W-1:0]     cellpix_wide;
    logic [WIDE_W-1:0]     own_wide;
    logic                  in_range;
    logic                  wants_color;
    logic [DOT_W-1:0]      mask;
    logic [DOT_W-1:0]      dot_new;
    logic                  slot_free;

    assign stride      = {cfg_cols, 1'b0};
    assign cell_sum    = rowbase_reg + PROD_W'(x_reg[X_W-1:1]);
    assign cellpix_wide = {rowbase_reg, 3'b000} + WIDE_W'({x_reg[X_W-1:1], 1'b0});
    assign own_wide    = {rowbase_reg, 3'b000} + WIDE_W'(offset_reg);
    assign in_range    = (cfg_cols != '0)
                      && ({1'b0, x_reg} < stride)
                      && (({1'b0, rowbase_reg} + (PROD_W + 1)'(cfg_cols))
                          <= (PROD_W + 1)'(MAX_CELLS));
    assign wants_color = (act_reg == ACT_SET_COLOR) || (act_reg == ACT_SET_BOTH);
    assign mask        = dot_mask(y_reg[1:0], x_reg[0]);
    assign slot_free   = !out_valid_reg || out_ready;

    always_comb begin
        unique case (act_reg)
            ACT_SET_DOT, ACT_SET_BOTH: dot_new = cell_rdata[DOT_W-1:0] | mask;
            ACT_CLEAR_DOT:             dot_new = cell_rdata[DOT_W-1:0] & ~mask;
            ACT_SET_COLOR:             dot_new = cell_rdata[DOT_W-1:0];
            default:                   dot_new = cell_rdata[DOT_W-1:0];
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        rgb_next       = rgb_reg;
        rowbase_next   = rowbase_reg;
        offset_next    = offset_reg;
        cell_next      = cell_reg;
        rowaddr_next   = rowaddr_reg;
        k_next         = k_reg;
        sum_r_next     = sum_r_reg;
        sum_g_next     = sum_g_reg;
        sum_b_next     = sum_b_reg;
        word_next      = word_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_dot_next   = out_dot_reg;
        out_r_next     = out_r_reg;
        out_g_next     = out_g_reg;
        out_b_next     = out_b_reg;
        out_oor_next   = out_oor_reg;

        in_ready   = 1'b0;
        cell_re    = 1'b0;
        cell_raddr = cell_sum[CELL_AW-1:0];
        cell_we    = 1'b0;
        cell_waddr = cell_reg;
        cell_wdata = word_reg;
        pix_re     = 1'b0;
        pix_raddr  = rowaddr_reg + PIX_AW'(k_reg[0]);
        pix_we     = 1'b0;
        pix_waddr  = own_wide[PIX_AW-1:0];
        pix_wdata  = rgb_reg;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = !clr_busy;
                if (in_valid && !clr_busy) begin
                    act_next   = action_t'(in_action);
                    x_next     = in_x;
                    y_next     = in_y;
                    rgb_next   = in_rgb;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                // cell row base and pixel offset within the cell row
                rowbase_next = PROD_W'(y_reg[Y_W-1:2] * cfg_cols);
                offset_next  = OFF_W'(y_reg[1:0]) * OFF_W'(stride) + OFF_W'(x_reg);
                state_next   = S_CHK;
            end
            S_CHK: begin
                if (in_range) begin
                    oor_next     = 1'b0;
                    cell_next    = cell_sum[CELL_AW-1:0];
                    rowaddr_next = cellpix_wide[PIX_AW-1:0];
                    cell_re      = 1'b1;
                    // store own pixel first so the sweep reads it back
                    pix_we       = wants_color;
                    state_next   = S_CELL;
                end else begin
                    oor_next   = 1'b1;
                    cell_next  = '0;
                    word_next  = '0;
                    state_next = S_DONE;
                end
            end
            S_CELL: begin
                word_next = {cell_rdata[CELL_W-1:DOT_W], dot_new};
                if (wants_color) begin
                    pix_re     = 1'b1;
                    pix_raddr  = rowaddr_reg;
                    k_next     = K_W'(1);
                    sum_r_next = '0;
                    sum_g_next = '0;
                    sum_b_next = '0;
                    state_next = S_SUM;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SUM: begin
                sum_r_next = sum_r_reg + SUM_W'(pix_rdata[COLOR_W-1:0]);
                sum_g_next = sum_g_reg + SUM_W'(pix_rdata[2*COLOR_W-1:COLOR_W]);
                sum_b_next = sum_b_reg + SUM_W'(pix_rdata[3*COLOR_W-1:2*COLOR_W]);
                if (k_reg == K_W'(PIX_PER_CELL)) begin
                    word_next  = {sum_b_next[SUM_W-1:3], sum_g_next[SUM_W-1:3],
                                  sum_r_next[SUM_W-1:3], word_reg[DOT_W-1:0]};
                    state_next = S_DONE;
                end else begin
                    pix_re = 1'b1;
                    if (k_reg[0]) begin
                        rowaddr_next = rowaddr_reg + PIX_AW'(stride);
                    end
                    k_next = k_reg + K_W'(1);
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    cell_we        = !oor_reg;
                    out_valid_next = 1'b1;
                    out_idx_next   = IDX_W'(cell_reg);
                    out_dot_next   = word_reg[DOT_W-1:0];
                    out_r_next     = word_reg[DOT_W+COLOR_W-1:DOT_W];
                    out_g_next     = word_reg[DOT_W+2*COLOR_W-1:DOT_W+COLOR_W];
                    out_b_next     = word_reg[CELL_W-1:DOT_W+2*COLOR_W];
                    out_oor_next   = oor_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        act_reg     <= act_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        rgb_reg     <= rgb_next;
        rowbase_reg <= rowbase_next;
        offset_reg  <= offset_next;
        cell_reg    <= cell_next;
        rowaddr_reg <= rowaddr_next;
        k_reg       <= k_next;
        sum_r_reg   <= sum_r_next;
        sum_g_reg   <= sum_g_next;
        sum_b_reg   <= sum_b_next;
        word_reg    <= word_next;
        oor_reg     <= oor_next;
        out_idx_reg <= out_idx_next;
        out_dot_reg <= out_dot_next;
        out_r_reg   <= out_r_next;
        out_g_reg   <= out_g_next;
        out_b_reg   <= out_b_next;
        out_oor_reg <= out_oor_next;
    end

    assign out_valid = out_valid_reg;
    assign out_idx   = out_idx_reg;
    assign out_dot   = out_dot_reg;
    assign out_red   = out_r_reg;
    assign out_green = out_g_reg;
    assign out_blue  = out_b_reg;
    assign out_oor   = out_oor_reg;

`ifndef SYNTHESIS
    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |-> !clr_busy)
        else $error("request taken during memory clear");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_oor_reg) |-> (out_idx_reg == '0 && out_dot_reg == '0
            && out_r_reg == '0 && out_g_reg == '0 && out_b_reg == '0))
        else $error("ignored request reports nonzero fields");

    a_sum_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM) |-> (k_reg != '0 && k_reg <= K_W'(PIX_PER_CELL)))
        else $error("pixel sweep count out of bounds");

    a_pix_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_we |-> (state_reg == S_CHK && in_range && wants_color))
        else $error("pixel write outside check phase");
`endif

endmodule

// File: rtl/braille_cell_plotter_unit.sv
// Channel  | Signals                          | Carries
// ---------+----------------------------------+------------------------------------------
// request  | s_tvalid s_tready s_tdata s_tuser| action, pixel x/y, pixel RGB
// result   | m_tvalid m_tready m_tdata m_tuser| cell index, dot byte, cell RGB, range flag
// config   | cfg_wr_en cfg_wr_data            | canvas width in cells
//
// A dot-only request steps through S_MUL, S_CHK, S_CELL and S_DONE from accept
// to result; a request that sets a color adds S_SUM, which sums the eight reads of
// the cell's pixels from the one pixel memory port. An out-of-range request skips S_CELL.
// After reset the memories are swept clear, every pixel entry once; s_tready stays
// low until the sweep ends, config writes still land.
// The result register holds a finished result while the next request is taken;
// a stalled m_tready only holds the engine at its final step.
module braille_cell_plotter_unit #(
    parameter int MAX_CELLS = brcp_pkg::MAX_CELLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config
    input  logic                              cfg_wr_en,
    input  logic [brcp_pkg::COL_W-1:0]        cfg_wr_data,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: pix_x[8:0], pix_y[22:9], red_in[30:23], green_in[38:31],
    //          blue_in[46:39], zero pad[47]
    input  logic [brcp_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: action[1:0]
    input  logic [brcp_pkg::ACTION_W-1:0]     s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: cell_index[11:0], dot_pattern[19:12], cell_red[27:20],
    //          cell_green[35:28], cell_blue[43:36], zero pad[47:44]
    output logic [brcp_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: out_of_range[0]
    output logic                              m_tuser
);
    import brcp_pkg::*;

    localparam int CELL_AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int PIX_DEPTH = MAX_CELLS * PIX_PER_CELL;
    localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int S_USED_W  = X_W + Y_W + 3 * COLOR_W;
    localparam int M_USED_W  = IDX_W + DOT_W + 3 * COLOR_W;

    // canvas width register
    logic [COL_W-1:0] cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RESET;
        end else if (cfg_wr_en) begin
            cols_reg <= cfg_wr_data;
        end
    end

    // unpack request fields
    logic [X_W-1:0]   in_x;
    logic [Y_W-1:0]   in_y;
    logic [PIX_W-1:0] in_rgb;

    assign in_x   = s_tdata[X_W-1:0];
    assign in_y   = s_tdata[X_W+Y_W-1:X_W];
    assign in_rgb = s_tdata[S_USED_W-1:X_W+Y_W];

    // clear sweep after reset
    clr_t              clr;
    logic [PIX_AW-1:0] clr_addr;

    brcp_clear #(
        .MAX_CELLS (MAX_CELLS)
    ) u_clear (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr      (clr),
        .clr_addr (clr_addr)
    );

    // engine <-> memory
    logic               eng_cell_re;
    logic [CELL_AW-1:0] eng_cell_raddr;
    logic [CELL_W-1:0]  cell_rdata;
    logic               eng_cell_we;
    logic [CELL_AW-1:0] eng_cell_waddr;
    logic [CELL_W-1:0]  eng_cell_wdata;
    logic               eng_pix_re;
    logic [PIX_AW-1:0]  eng_pix_raddr;
    logic [PIX_W-1:0]   pix_rdata;
    logic               eng_pix_we;
    logic [PIX_AW-1:0]  eng_pix_waddr;
    logic [PIX_W-1:0]   eng_pix_wdata;

    logic [IDX_W-1:0]   out_idx;
    logic [DOT_W-1:0]   out_dot;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               out_oor;

    brcp_engine #(
        .MAX_CELLS (MAX_CELLS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_cols   (cols_reg),
        .clr_busy   (clr.busy),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser),
        .in_x       (in_x),
        .in_y       (in_y),
        .in_rgb     (in_rgb),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_idx    (out_idx),
        .out_dot    (out_dot),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_oor    (out_oor),
        .cell_re    (eng_cell_re),
        .cell_raddr (eng_cell_raddr),
        .cell_rdata (cell_rdata),
        .cell_we    (eng_cell_we),
        .cell_waddr (eng_cell_waddr),
        .cell_wdata (eng_cell_wdata),
        .pix_re     (eng_pix_re),
        .pix_raddr  (eng_pix_raddr),
        .pix_rdata  (pix_rdata),
        .pix_we     (eng_pix_we),
        .pix_waddr  (eng_pix_waddr),
        .pix_wdata  (eng_pix_wdata)
    );

    // Memory write ports: the sweep owns them while busy, the engine is idle then
    logic               cell_we;
    logic [CELL_AW-1:0] cell_waddr;
    logic [CELL_W-1:0]  cell_wdata;
    logic               pix_we;
    logic [PIX_AW-1:0]  pix_waddr;
    logic [PIX_W-1:0]   pix_wdata;

    assign cell_we    = clr.cell_we || eng_cell_we;
    assign cell_waddr = clr.busy ? clr_addr[CELL_AW-1:0] : eng_cell_waddr;
    assign cell_wdata = clr.busy ? CELL_RESET_WORD : eng_cell_wdata;
    assign pix_we     = clr.pix_we || eng_pix_we;
    assign pix_waddr  = clr.busy ? clr_addr : eng_pix_waddr;
    assign pix_wdata  = clr.busy ? '0 : eng_pix_wdata;

    // dot byte and cell color, one word per cell
    brcp_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_CELLS)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (eng_cell_re),
        .raddr (eng_cell_raddr),
        .rdata (cell_rdata)
    );

    // per-pixel color, row-major at two pixels per cell column
    brcp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIX_DEPTH)
    ) u_pix_ram (
        .aclk  (aclk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .re    (eng_pix_re),
        .raddr (eng_pix_raddr),
        .rdata (pix_rdata)
    );

    // pack result fields, pad to whole bytes
    assign m_tdata = {{(M_TDATA_W - M_USED_W){1'b0}},
                      out_blue, out_green, out_red, out_dot, out_idx};
    assign m_tuser = out_oor;

`ifndef SYNTHESIS
    a_clear_owns_ram: assert property (@(posedge aclk) disable iff (!aresetn)
        (eng_cell_we || eng_pix_we) |-> !clr.busy)
        else $error("engine wrote memory during clear sweep");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import brcp_pkg::*;

    localparam int MAX_CELLS   = MAX_CELLS_DEF;
    localparam int PIX_CELLS   = PIX_PER_CELL * MAX_CELLS;
    // Quiet cycles allowed before the run is declared hung; the post-reset
    // memory sweep alone runs with no traffic at all.
    localparam int QUIET_LIMIT = 4 * PIX_CELLS;
    // Dot bit for {row within cell, column within cell}, one byte per entry,
    // entry 0 in the low byte.
    localparam logic [63:0] BRAILLE_BITS = 64'h8040_2004_1002_0801;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [IDX_W-1:0]   cell_index;
        logic [DOT_W-1:0]   dots;
        rgb_t               color;
        logic               out_of_range;
    } cell_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [COL_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    // s_tdata: pix_x, pix_y, red, green, blue, zero pad (low bit up)
    logic [S_TDATA_W-1:0] s_tdata;
    // s_tuser: action
    logic [ACTION_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // m_tdata: cell_index, dot_pattern, cell red, green, blue, zero pad (low bit up)
    logic [M_TDATA_W-1:0] m_tdata;
    // m_tuser: out_of_range
    logic                 m_tuser;

    // Shadow copy of the canvas: width register, dot bytes, pixel and cell colors
    int unsigned          canvas_cols;
    logic [DOT_W-1:0]     dot_mem [MAX_CELLS];
    rgb_t                 pixel_mem [PIX_CELLS];
    rgb_t                 cell_rgb_mem [MAX_CELLS];

    cell_result_t         pending_cells [$];
    int                   err_count;
    int                   quiet_cycles;
    bit                   no_idle;

    braille_cell_plotter_unit #(
        .MAX_CELLS   (MAX_CELLS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Canvas predictor: apply one request to the shadow canvas and return
    // the result the block must report for it.
    // ------------------------------------------------------------------
    function automatic cell_result_t plot_pixel(input action_t act,
                                                input logic [X_W-1:0] x,
                                                input logic [Y_W-1:0] y,
                                                input rgb_t rgb);
        cell_result_t res;
        int unsigned  w;
        int unsigned  rows;
        int unsigned  cell_num;
        int unsigned  stride;
        int unsigned  base_x;
        int unsigned  base_y;
        int unsigned  sum_r;
        int unsigned  sum_g;
        int unsigned  sum_b;
        rgb_t         px;
        logic [DOT_W-1:0] mask;

        res  = '0;
        w    = canvas_cols;
        rows = (w == 0) ? 0 : MAX_CELLS / w;
        // Outside the canvas (or no canvas at all): leave state alone, flag it
        if (w == 0 || x >= 2 * w || (y >> 2) >= rows) begin
            res.out_of_range = 1'b1;
            return res;
        end

        cell_num = (y >> 2) * w + (x >> 1);
        mask     = BRAILLE_BITS[{y[1:0], x[0]} * 8 +: 8];

        case (act)
            ACT_SET_DOT, ACT_SET_BOTH: dot_mem[cell_num] = dot_mem[cell_num] | mask;
            ACT_CLEAR_DOT:             dot_mem[cell_num] = dot_mem[cell_num] & ~mask;
            default: ;
        endcase

        // Color write: store the pixel, then average all eight of its cell
        if (act == ACT_SET_COLOR || act == ACT_SET_BOTH) begin
            stride = w << 1;
            base_x = (x >> 1) << 1;
            base_y = (y >> 2) << 2;
            sum_r  = 0;
            sum_g  = 0;
            sum_b  = 0;
            pixel_mem[y * stride + x] = rgb;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 2; c++) begin
                    px = pixel_mem[(base_y + r) * stride + base_x + c];
                    sum_r += px.red;
                    sum_g += px.green;
                    sum_b += px.blue;
                end
            end
            cell_rgb_mem[cell_num] = '{COLOR_W'(sum_r >> 3), COLOR_W'(sum_g >> 3),
                                       COLOR_W'(sum_b >> 3)};
        end

        res.cell_index = IDX_W'(cell_num);
        res.dots       = dot_mem[cell_num];
        res.color      = cell_rgb_mem[cell_num];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: idle at random, present one request, hold it until
    // accepted, then predict. Returns on the following falling edge with
    // s_tvalid still high so back-to-back requests need no dead cycle.
    // ------------------------------------------------------------------
    task automatic send_request(input action_t act, input logic [X_W-1:0] x,
                                input logic [Y_W-1:0] y, input rgb_t rgb);
        while (!no_idle && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, rgb.blue, rgb.green, rgb.red, y, x};
        do @(posedge aclk); while (!s_tready);
        pending_cells.push_back(plot_pixel(act, x, y, rgb));
        @(negedge aclk);
    endtask

    // Drop s_tvalid and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0)
            @(negedge aclk);
    endtask

    // Write the width register once the block has gone idle
    task automatic set_canvas_width(input int unsigned cols);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COL_W'(cols);
        canvas_cols  = cols & ((1 << COL_W) - 1);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [COLOR_W-1:0] pick_shade();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random traffic for the current width. Mostly in-canvas requests,
    // a good share packed into a few corner cells so colors and dots pile
    // up, occasional whole-cell paint runs, and some raw noise that mostly
    // lands off the canvas.
    // ------------------------------------------------------------------
    task automatic send_random_requests(input int count);
        int unsigned  lim_x;
        int unsigned  lim_y;
        int unsigned  mode;
        int           sent;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        action_t      act;

        sent = 0;
        while (sent < count) begin
            if (canvas_cols != 0) begin
                lim_x = (2 * canvas_cols > 512) ? 512 : 2 * canvas_cols;
                lim_y = 4 * (MAX_CELLS / canvas_cols);
                lim_y = (lim_y > 16384) ? 16384 : lim_y;
            end else begin
                lim_x = 0;
                lim_y = 0;
            end
            mode = $urandom_range(99);
            if (lim_x != 0 && mode < 10) begin
                // Paint every pixel of one cell, in order, then read back the average
                x   = X_W'(($urandom_range(lim_x - 1) >> 1) << 1);
                y   = Y_W'(($urandom_range(lim_y - 1) >> 2) << 2);
                act = ($urandom_range(1) != 0) ? ACT_SET_BOTH : ACT_SET_COLOR;
                for (int p = 0; p < PIX_PER_CELL; p++)
                    send_request(act, x + X_W'(p & 1), y + Y_W'(p >> 1),
                                 '{pick_shade(), pick_shade(), pick_shade()});
                sent += PIX_PER_CELL;
            end else begin
                act = action_t'($urandom_range(3));
                if (lim_x != 0 && mode < 50) begin
                    x = X_W'($urandom_range((lim_x > 6 ? 6 : lim_x) - 1));
                    y = Y_W'($urandom_range((lim_y > 8 ? 8 : lim_y) - 1));
                end else if (lim_x != 0 && mode < 82) begin
                    x = X_W'($urandom_range(lim_x - 1));
                    y = Y_W'($urandom_range(lim_y - 1));
                end else begin
                    x = X_W'($urandom);
                    y = Y_W'($urandom);
                end
                send_request(act, x, y, '{pick_shade(), pick_shade(), pick_shade()});
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default width: fill cell 0 pixel by pixel, clear a dot, recolor,
    // touch the last cell and the first cells past each edge.
    task automatic test_default_canvas();
        set_canvas_width(80);
        for (int p = 0; p < PIX_PER_CELL; p++)
            send_request(ACT_SET_BOTH, X_W'(p & 1), Y_W'(p >> 1),
                         '{8'(p * 32), 8'(255 - p * 16), 8'(p * 7)});
        send_request(ACT_CLEAR_DOT, 9'd1, 14'd2, '{8'hFF, 8'hFF, 8'hFF});
        send_request(ACT_SET_COLOR, 9'd0, 14'd0, '{8'hFF, 8'hFF, 8'hFF});
        // Untouched cell still reports the white reset color
        send_request(ACT_SET_DOT, 9'd2, 14'd4, '{8'h00, 8'h00, 8'h00});
        // Last in-range cell at width 80: 51 full rows
        send_request(ACT_SET_DOT, 9'd159, 14'd203, '{8'h00, 8'h00, 8'h00});
        send_request(ACT_SET_COLOR, 9'd159, 14'd203, '{8'hFF, 8'h00, 8'hFF});
        send_request(ACT_SET_BOTH, 9'd160, 14'd0, '{8'hFF, 8'hFF, 8'hFF});
        send_request(ACT_SET_BOTH, 9'd0, 14'd204, '{8'hFF, 8'hFF, 8'hFF});
        send_request(ACT_SET_DOT, 9'd511, 14'd16383, '{8'hFF, 8'hFF, 8'hFF});
    endtask

    // Zero width: nothing is on the canvas
    task automatic test_zero_width();
        set_canvas_width(0);
        send_request(ACT_SET_BOTH, 9'd0, 14'd0, '{8'h12, 8'h34, 8'h56});
        send_request(ACT_CLEAR_DOT, 9'd1, 14'd3, '{8'h00, 8'h00, 8'h00});
        send_random_requests(6);
    endtask

    // One cell wide: 4096 rows, the full y range is on the canvas
    task automatic test_single_column();
        set_canvas_width(1);
        send_request(ACT_SET_BOTH, 9'd1, 14'd16383, '{8'hFF, 8'hFF, 8'hFF});
        send_request(ACT_SET_DOT, 9'd0, 14'd16380, '{8'h00, 8'h00, 8'h00});
        send_request(ACT_SET_COLOR, 9'd2, 14'd0, '{8'hAA, 8'h55, 8'hAA});
        send_random_requests(150);
    endtask

    // Widths past the nominal maximum and at it; run one phase with no idling
    task automatic test_wide_canvas();
        set_canvas_width(511);
        send_request(ACT_SET_BOTH, 9'd511, 14'd31, '{8'h80, 8'h7F, 8'h01});
        send_request(ACT_SET_DOT, 9'd0, 14'd32, '{8'h00, 8'h00, 8'h00});
        send_random_requests(150);
        set_canvas_width(256);
        no_idle = 1'b1;
        send_random_requests(150);
        drain_results();
        no_idle = 1'b0;
    endtask

    // Assorted widths, including one that does not divide the cell count
    task automatic test_random_widths();
        int unsigned widths [4];

        widths = '{3, 100, 80, $urandom_range(1, 511)};
        foreach (widths[i]) begin
            set_canvas_width(widths[i]);
            send_random_requests(120);
        end
        set_canvas_width($urandom_range(1, 511));
        send_random_requests(120);
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every accepted result with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        cell_result_t want;

        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cells.size() == 0) begin
                $error("result with no request outstanding: m_tdata %h m_tuser %b",
                       m_tdata, m_tuser);
                err_count++;
            end else begin
                want = pending_cells.pop_front();
                compare_field("out_of_range", want.out_of_range, m_tuser);
                compare_field("cell_index", want.cell_index, m_tdata[11:0]);
                compare_field("dot_pattern", want.dots, m_tdata[19:12]);
                compare_field("cell_red", want.color.red, m_tdata[27:20]);
                compare_field("cell_green", want.color.green, m_tdata[35:28]);
                compare_field("cell_blue", want.color.blue, m_tdata[43:36]);
            end
        end
    end

    // Result backpressure: stall about a third of the cycles unless a
    // no-idle phase is running
    always @(negedge aclk)
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);

    // Hang detector: count cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_SET_DOT;
        m_tready     = 1'b0;
        no_idle      = 1'b0;
        err_count    = 0;
        quiet_cycles = 0;
        canvas_cols  = 80;
        // Shadow canvas starts as reset leaves the block: blank dots,
        // black pixels, white cells
        for (int i = 0; i < MAX_CELLS; i++) begin
            dot_mem[i]      = '0;
            cell_rgb_mem[i] = '1;
        end
        for (int i = 0; i < PIX_CELLS; i++)
            pixel_mem[i] = '0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_default_canvas();
        test_zero_width();
        test_single_column();
        test_wide_canvas();
        test_random_widths();

        // Drain, then leave room for any stray late result
        drain_results();
        repeat (20) @(negedge aclk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
